### rtl/core/vmts_pkg.sv
package vmts_pkg;

  localparam int DEF_COUNT_BITS = 20;
  localparam int NUM_MONTHS     = 12;
  localparam int NUM_ENTRIES    = NUM_MONTHS + 1;  // entry 0 is the whole year
  localparam int ENT_ADDR_BITS  = $clog2(NUM_ENTRIES);

  localparam int TEMP_BITS      = 8;
  localparam int SUM_EXTRA      = 8;   // sum width is count width plus this
  localparam int FRAC_BITS      = 8;   // Q8.8 average
  localparam int QUOT_BITS      = 15;  // |avg| <= 99 * 256 < 2**15
  localparam int AVG_BITS       = QUOT_BITS + 1;
  localparam int COUNT_OUT_BITS = 20;

  localparam int IN_DATA_BITS   = 56;
  localparam int OUT_DATA_BITS  = 56;

  localparam logic signed [TEMP_BITS-1:0] TEMP_HIGH = 8'sd99;
  localparam logic signed [TEMP_BITS-1:0] TEMP_LOW  = -8'sd99;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MAX = 8'd59;

  // mode codes (tuser)
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // floor(y / 25) = (y * LEAP_MUL) >> LEAP_SHIFT, exact for 16-bit y
  localparam logic [16:0] LEAP_MUL   = 17'd83887;
  localparam int          LEAP_SHIFT = 21;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic [COUNT_OUT_BITS-1:0]  record_count;
    logic signed [AVG_BITS-1:0] temp_avg_q8;
    logic signed [TEMP_BITS-1:0] temp_max;
    logic signed [TEMP_BITS-1:0] temp_min;
    logic                       stat_empty;
    logic                       limit_reached;
    logic                       record_accepted;
  } out_word_t;

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic lp);
    logic [4:0] d;
    case (m) inside
      MONTH_FEB:                                d = lp ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
      default:                                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/vmts_div.sv
// Restoring divider: (mag << FRAC_BITS) / divisor, one quotient bit per cycle.
// Caller guarantees mag <= 99 * divisor, so the quotient fits QUOT_BITS.
module vmts_div import vmts_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [COUNT_BITS+SUM_EXTRA-2:0]    mag,
  input  logic [COUNT_BITS-1:0]              divisor,
  output div_res_t                           res
);

  localparam int MagW = COUNT_BITS + SUM_EXTRA - 1;
  localparam int DvdW = MagW + FRAC_BITS;
  localparam int CntW = $clog2(QUOT_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CntW-1:0]       cnt_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] div_r;
  logic [QUOT_BITS-1:0]  sh_r;
  logic [QUOT_BITS-1:0]  quot_r;

  logic [DvdW-1:0]       dvd;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign dvd   = {mag, {FRAC_BITS{1'b0}}};
  assign trial = {rem_r, sh_r[QUOT_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(QUOT_BITS - 1);
        rem_r  <= dvd[DvdW-1:QUOT_BITS];
        sh_r   <= dvd[QUOT_BITS-1:0];
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        sh_r   <= {sh_r[QUOT_BITS-2:0], 1'b0};
        quot_r <= {quot_r[QUOT_BITS-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CntW'(1);
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < div_r) else $error("partial remainder not below divisor");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without finished run");

endmodule

### rtl/core/validated_monthly_temp_stats.sv
// Record word: ST_CHECK, ST_YEAR, ST_MONTH, ST_OUT after accept (no ST_MONTH when refused);
// next word taken back in ST_IDLE. Query word: ST_CHECK, then ST_DIV as the serial divider
// gives one quotient bit per cycle over 15 bits, then ST_OUT; an empty period skips ST_DIV.
// Accumulators sit in one 13-entry memory (year + months), one read and one write port.
// Reset (rst_n low, synchronous) clears expected_year and the per-entry valid bits; an
// entry never written reads as empty, so no clearing pass is needed.
module validated_monthly_temp_stats import vmts_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // year[15:0], month[23:16], day[31:24], hour[39:32], minute[47:40], temp[55:48]
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // mode[0]
  input  logic [0:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // record_accepted[0], limit_reached[1], stat_empty[2], temp_min[10:3],
  // temp_max[18:11], temp_avg_q8[34:19], record_count[54:35], zero[55]
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  localparam int SumW    = COUNT_BITS + SUM_EXTRA;
  localparam int CntExtW = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;

  typedef struct packed {
    logic signed [SumW-1:0]      sum;
    logic [COUNT_BITS-1:0]       cnt;
    logic signed [TEMP_BITS-1:0] tmin;
    logic signed [TEMP_BITS-1:0] tmax;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_YEAR, ST_MONTH, ST_DIV, ST_OUT
  } state_t;

  localparam entry_t ENT_RESET = '{sum: '0, cnt: '0, tmin: TEMP_HIGH, tmax: TEMP_LOW};

  function automatic entry_t ent_add(input entry_t e, input logic signed [TEMP_BITS-1:0] t);
    entry_t r;
    r.sum  = e.sum + {{(SumW-TEMP_BITS){t[TEMP_BITS-1]}}, t};
    r.cnt  = e.cnt + COUNT_BITS'(1);
    r.tmin = (t < e.tmin) ? t : e.tmin;
    r.tmax = (t > e.tmax) ? t : e.tmax;
    return r;
  endfunction

  // accumulator memory
  entry_t mem [NUM_ENTRIES];
  entry_t rd_data_r;

  state_t state_r, state_nxt;
  logic [15:0]                 exp_year_r;
  logic [NUM_ENTRIES-1:0]      valid_r;
  logic                        rd_valid_r;
  logic                        f_mode_r;
  logic [15:0]                 f_year_r;
  logic [7:0]                  f_month_r, f_day_r, f_hour_r, f_min_r;
  logic signed [TEMP_BITS-1:0] f_temp_r;
  logic                        rec_ok_r, rec_ok_nxt;
  logic                        neg_r, neg_nxt;
  entry_t                      mon_r, mon_nxt;
  out_word_t                   res_r, res_nxt;
  out_word_t                   out_r, out_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;

  logic [ENT_ADDR_BITS-1:0]    rd_addr, wr_addr;
  logic                        wr_en;
  entry_t                      wr_data;
  entry_t                      ent_rd;

  logic                        in_acc;
  logic [7:0]                  in_month;

  logic [32:0]                 leap_prod;
  logic [11:0]                 y_div25;
  logic [15:0]                 y_back25;
  logic                        leap_yr;
  logic [4:0]                  dim;

  logic signed [SumW-1:0]      abs_sum;
  logic                        div_start;
  div_res_t                    div_res;
  logic [AVG_BITS-1:0]         quot_ext;
  logic [CntExtW-1:0]          cnt_ext;
  logic                        q_empty;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_month  = in_tdata[23:16];

  assign ent_rd = rd_valid_r ? rd_data_r : ENT_RESET;

  // leap year: divisible by 4 and (not by 100, or by 400) == (not by 25, or by 16)
  assign leap_prod = f_year_r * LEAP_MUL;
  assign y_div25   = leap_prod[32:LEAP_SHIFT];
  assign y_back25  = 16'({y_div25, 4'b0}) + 16'({y_div25, 3'b0}) + 16'(y_div25);
  assign leap_yr   = (f_year_r[1:0] == 2'b00) &&
                     ((y_back25 != f_year_r) || (f_year_r[3:0] == 4'b0000));
  assign dim       = month_length(f_month_r[3:0], leap_yr);

  assign abs_sum   = ent_rd.sum[SumW-1] ? -ent_rd.sum : ent_rd.sum;
  assign quot_ext  = {1'b0, div_res.quot};
  assign cnt_ext   = CntExtW'(ent_rd.cnt);
  assign q_empty   = (f_month_r > 8'(NUM_MONTHS)) || (ent_rd.cnt == '0);
  assign div_start = (state_r == ST_CHECK) && (f_mode_r == MODE_QUERY) && !q_empty;

  vmts_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (abs_sum[SumW-2:0]),
    .divisor (ent_rd.cnt),
    .res     (div_res)
  );

  always_comb begin
    state_nxt      = state_r;
    rec_ok_nxt     = rec_ok_r;
    neg_nxt        = neg_r;
    mon_nxt        = mon_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = ent_add(ent_rd, f_temp_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_month <= 8'(NUM_MONTHS)) begin
          rd_addr = in_month[ENT_ADDR_BITS-1:0];
        end
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // month entry on the read port now; fetch the year entry next
        mon_nxt    = ent_rd;
        res_nxt    = '0;
        rec_ok_nxt = (f_year_r == exp_year_r) &&
                     (f_month_r != 8'd0) && (f_month_r <= 8'(NUM_MONTHS)) &&
                     (f_day_r != 8'd0) && (f_day_r <= {3'b000, dim}) &&
                     (f_hour_r <= HOUR_MAX) && (f_min_r <= MINUTE_MAX) &&
                     (f_temp_r >= TEMP_LOW) && (f_temp_r <= TEMP_HIGH);
        if (f_mode_r == MODE_RECORD) begin
          state_nxt = ST_YEAR;
        end else if (q_empty) begin
          res_nxt.stat_empty = 1'b1;
          res_nxt.temp_min   = TEMP_HIGH;
          res_nxt.temp_max   = TEMP_LOW;
          state_nxt          = ST_OUT;
        end else begin
          res_nxt.temp_min     = ent_rd.tmin;
          res_nxt.temp_max     = ent_rd.tmax;
          res_nxt.record_count = cnt_ext[COUNT_OUT_BITS-1:0];
          neg_nxt              = ent_rd.sum[SumW-1];
          state_nxt            = ST_DIV;
        end
      end
      ST_YEAR: begin
        if (!rec_ok_r) begin
          state_nxt = ST_OUT;
        end else if (&ent_rd.cnt) begin
          res_nxt.limit_reached = 1'b1;
          state_nxt             = ST_OUT;
        end else begin
          wr_en                   = 1'b1;
          res_nxt.record_accepted = 1'b1;
          state_nxt               = ST_MONTH;
        end
      end
      ST_MONTH: begin
        wr_en     = 1'b1;
        wr_addr   = f_month_r[ENT_ADDR_BITS-1:0];
        wr_data   = ent_add(mon_r, f_temp_r);
        state_nxt = ST_OUT;
      end
      ST_DIV: begin
        if (div_res.done) begin
          res_nxt.temp_avg_q8 = neg_r ? -quot_ext : quot_ext;
          state_nxt           = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_nxt        = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      exp_year_r   <= '0;
      valid_r      <= '0;
      rd_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_valid_r   <= valid_r[rd_addr];
      if (cfg_we) begin
        exp_year_r <= cfg_wdata;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
    if (in_acc) begin
      f_mode_r  <= in_tuser[0];
      f_year_r  <= in_tdata[15:0];
      f_month_r <= in_tdata[23:16];
      f_day_r   <= in_tdata[31:24];
      f_hour_r  <= in_tdata[39:32];
      f_min_r   <= in_tdata[47:40];
      f_temp_r  <= in_tdata[55:48];
    end
    rec_ok_r <= rec_ok_nxt;
    neg_r    <= neg_nxt;
    mon_r    <= mon_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-$bits(out_word_t)){1'b0}}, out_r};

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_addr < ENT_ADDR_BITS'(NUM_ENTRIES)) else $error("write beyond memory");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_YEAR) || (state_r == ST_MONTH))
    else $error("memory write outside record update");

  a_year_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MONTH |-> $past(wr_en) && ($past(wr_addr) == '0))
    else $error("month update without year update");

  a_acc_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_r.record_accepted |-> !out_r.limit_reached && !out_r.stat_empty)
    else $error("conflicting result flags");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_r.stat_empty |->
      (out_r.record_count == '0) && (out_r.temp_avg_q8 == '0) &&
      (out_r.temp_min == TEMP_HIGH) && (out_r.temp_max == TEMP_LOW))
    else $error("empty result with stale fields");

endmodule

### bench/validated_monthly_temp_stats_tb.sv
module validated_monthly_temp_stats_tb import vmts_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 200;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_PCT     = 27;
  localparam longint unsigned COUNT_CAP = (64'd1 << DEF_COUNT_BITS) - 1;

  typedef struct {
    logic                  mode;
    logic [15:0]           yr;
    logic [7:0]            mo;
    logic [7:0]            dy;
    logic [7:0]            hr;
    logic [7:0]            mi;
    logic signed [7:0]     tc;
    bit                    typed;
    out_word_t             want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [15:0]              cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [0:0]               in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  // accumulator copy: entry 0 is the whole year, 1..12 the months
  longint          acc_sum [0:NUM_MONTHS];
  longint unsigned acc_cnt [0:NUM_MONTHS];
  int              acc_min [0:NUM_MONTHS];
  int              acc_max [0:NUM_MONTHS];
  logic [15:0]     cur_year;

  out_word_t expected_words[$];
  stim_row_t directed_rows[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;

  validated_monthly_temp_stats u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit is_leap_year(input logic [15:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input logic [7:0] mo, input logic [15:0] y);
    case (mo) inside
      8'd2:                     return is_leap_year(y) ? 29 : 28;
      8'd4, 8'd6, 8'd9, 8'd11:  return 30;
      default:                  return 31;
    endcase
  endfunction

  function automatic void stats_reset();
    for (int i = 0; i <= NUM_MONTHS; i++) begin
      acc_sum[i] = 0;
      acc_cnt[i] = 0;
      acc_min[i] = 99;
      acc_max[i] = -99;
    end
    cur_year = '0;
  endfunction

  function automatic out_word_t stats_predict(input stim_row_t r);
    out_word_t res;
    int        t;
    int        e;
    longint    avg;
    bit        ok;
    res = '0;
    t = r.tc;
    if (r.mode == MODE_RECORD) begin
      ok = (r.yr == cur_year) && (r.mo >= 1) && (r.mo <= NUM_MONTHS) && (r.dy >= 1)
        && (r.dy <= month_days(r.mo, r.yr)) && (r.hr <= 23) && (r.mi <= 59)
        && (t >= -99) && (t <= 99);
      if (ok) begin
        if (acc_cnt[0] >= COUNT_CAP) begin
          res.limit_reached = 1'b1;
        end else begin
          foreach (acc_sum[i]) begin
            if (i == 0 || i == r.mo) begin
              acc_sum[i] += t;
              acc_cnt[i] += 1;
              if (t < acc_min[i]) acc_min[i] = t;
              if (t > acc_max[i]) acc_max[i] = t;
            end
          end
          res.record_accepted = 1'b1;
        end
      end
    end else begin
      e = (r.mo <= NUM_MONTHS) ? int'(r.mo) : -1;
      if (e < 0 || acc_cnt[e] == 0) begin
        res.stat_empty = 1'b1;
        res.temp_min   = TEMP_HIGH;
        res.temp_max   = TEMP_LOW;
      end else begin
        avg = (acc_sum[e] * 256) / longint'(acc_cnt[e]);
        res.temp_min     = acc_min[e][7:0];
        res.temp_max     = acc_max[e][7:0];
        res.temp_avg_q8  = avg[15:0];
        res.record_count = acc_cnt[e][19:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got_v, exp_v,
             cycle_count);
    error_count++;
  endtask

  // caller sits at a falling edge; returns at the falling edge after the handshake
  task automatic send_word(input stim_row_t r);
    out_word_t pred;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {r.tc, r.mi, r.hr, r.dy, r.mo, r.yr};
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = stats_predict(r);
    expected_words.push_back(r.typed ? r.want : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_year(input logic [15:0] y);
    in_tvalid <= 1'b0;
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= y;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_year = y;
  endtask

  task automatic add_row(input logic m, input logic [15:0] y, input logic [7:0] mo,
                         input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi,
                         input logic signed [7:0] t, input bit typed, input out_word_t w);
    stim_row_t r;
    r.mode = m;  r.yr = y;  r.mo = mo;  r.dy = d;  r.hr = h;  r.mi = mi;  r.tc = t;
    r.typed = typed;
    r.want = w;
    directed_rows.push_back(r);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        kind;
    int        dim;
    r.typed = 1'b0;
    r.want  = '0;
    r.mode  = MODE_RECORD;
    r.yr    = cur_year;
    r.mo    = 8'($urandom_range(1, 12));
    dim     = month_days(r.mo, r.yr);
    r.dy    = ($urandom_range(0, 3) == 0) ? 8'(dim) : 8'($urandom_range(1, dim));
    r.hr    = 8'($urandom_range(0, 23));
    r.mi    = 8'($urandom_range(0, 59));
    r.tc    = 8'($urandom_range(0, 198) - 99);
    kind    = $urandom_range(0, 99);
    if (kind < 55) begin
      // well-formed record
    end else if (kind < 75) begin
      r.mode = MODE_QUERY;
      r.yr   = 16'($urandom);
      r.mo   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 12))
                                            : 8'($urandom_range(13, 255));
      r.dy   = 8'($urandom);
      r.hr   = 8'($urandom);
      r.mi   = 8'($urandom);
      r.tc   = 8'($urandom);
    end else if (kind < 88) begin
      // one broken field
      case ($urandom_range(0, 5))
        0: r.yr = cur_year ^ 16'($urandom_range(1, 65535));
        1: r.mo = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(13, 255));
        2: begin
          case ($urandom_range(0, 2))
            0:       r.dy = 8'd0;
            1:       r.dy = 8'(dim + 1);
            default: r.dy = 8'($urandom_range(32, 255));
          endcase
        end
        3: r.hr = 8'($urandom_range(24, 255));
        4: r.mi = 8'($urandom_range(60, 255));
        default: r.tc = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(100, 127))
                                                    : 8'(-$urandom_range(100, 128));
      endcase
    end else begin
      r.yr = 16'($urandom);
      r.mo = 8'($urandom);
      r.dy = 8'($urandom);
      r.hr = 8'($urandom);
      r.mi = 8'($urandom);
      r.tc = 8'($urandom);
    end
    return r;
  endfunction

  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_word_t got;
    out_word_t exp_w;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_word_t'(out_tdata[$bits(out_word_t)-1:0]);
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, record_count", got.record_count, -1);
      end else begin
        exp_w = expected_words.pop_front();
        if (got.record_accepted !== exp_w.record_accepted)
          report_mismatch("record_accepted", got.record_accepted, exp_w.record_accepted);
        if (got.limit_reached !== exp_w.limit_reached)
          report_mismatch("limit_reached", got.limit_reached, exp_w.limit_reached);
        if (got.stat_empty !== exp_w.stat_empty)
          report_mismatch("stat_empty", got.stat_empty, exp_w.stat_empty);
        if (got.temp_min !== exp_w.temp_min)
          report_mismatch("temp_min", got.temp_min, exp_w.temp_min);
        if (got.temp_max !== exp_w.temp_max)
          report_mismatch("temp_max", got.temp_max, exp_w.temp_max);
        if (got.temp_avg_q8 !== exp_w.temp_avg_q8)
          report_mismatch("temp_avg_q8", got.temp_avg_q8, exp_w.temp_avg_q8);
        if (got.record_count !== exp_w.record_count)
          report_mismatch("record_count", got.record_count, exp_w.record_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_years [7];
    out_word_t   w_empty;
    out_word_t   w_acc;
    out_word_t   w_rej;

    stats_reset();
    w_rej = '0;
    w_acc = '0;
    w_acc.record_accepted = 1'b1;
    w_empty = '0;
    w_empty.stat_empty = 1'b1;
    w_empty.temp_min   = TEMP_HIGH;
    w_empty.temp_max   = TEMP_LOW;

    // year register is 0 after reset; year 0 is a leap year by the 400 rule
    add_row(MODE_QUERY,  16'd0,     8'd0,   8'd0,  8'd0,  8'd0,  8'sd0,    1, w_empty);
    add_row(MODE_QUERY,  16'd0,     8'd13,  8'd0,  8'd0,  8'd0,  8'sd0,    1, w_empty);
    add_row(MODE_QUERY,  16'hFFFF,  8'd255, 8'hFF, 8'hFF, 8'hFF, -8'sd1,   1, w_empty);
    add_row(MODE_RECORD, 16'd0,     8'd1,   8'd1,  8'd0,  8'd0,  -8'sd99,  1, w_acc);
    add_row(MODE_RECORD, 16'd0,     8'd12,  8'd31, 8'd23, 8'd59, 8'sd99,   1, w_acc);
    add_row(MODE_RECORD, 16'd0,     8'd2,   8'd29, 8'd12, 8'd30, 8'sd0,    1, w_acc);
    add_row(MODE_RECORD, 16'd0,     8'd2,   8'd30, 8'd12, 8'd30, 8'sd0,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd4,   8'd31, 8'd1,  8'd1,  8'sd5,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd4,   8'd30, 8'd1,  8'd1,  8'sd5,    1, w_acc);
    add_row(MODE_RECORD, 16'd1,     8'd3,   8'd3,  8'd3,  8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'hFFFF,  8'd3,   8'd3,  8'd3,  8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd0,   8'd3,  8'd3,  8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd13,  8'd3,  8'd3,  8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd0,  8'd3,  8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd24, 8'd3,  8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd3,  8'd60, 8'sd3,    1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd3,  8'd3,  8'sd100,  1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd3,  8'd3,  -8'sd100, 1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd3,  8'd3,  8'sd127,  1, w_rej);
    add_row(MODE_RECORD, 16'd0,     8'd3,   8'd3,  8'd3,  8'd3,  -8'sd128, 1, w_rej);
    add_row(MODE_RECORD, 16'hFFFF,  8'hFF,  8'hFF, 8'hFF, 8'hFF, -8'sd1,   1, w_rej);
    add_row(MODE_QUERY,  16'hFFFF,  8'd1,   8'hFF, 8'hFF, 8'hFF, -8'sd1,   0, w_rej);
    add_row(MODE_QUERY,  16'd0,     8'd2,   8'd0,  8'd0,  8'd0,  8'sd0,    0, w_rej);
    add_row(MODE_QUERY,  16'd0,     8'd4,   8'd0,  8'd0,  8'd0,  8'sd0,    0, w_rej);
    add_row(MODE_QUERY,  16'd0,     8'd0,   8'd0,  8'd0,  8'd0,  8'sd0,    0, w_rej);

    phase_years = '{16'd1900, 16'd2000, 16'd2024, 16'd2023, 16'hFFFF, 16'd0,
                    16'($urandom)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    foreach (phase_years[p]) begin
      write_year(phase_years[p]);
      quiet = (p == 2);  // one phase runs with both sides always ready
      repeat (PHASE_ITEMS) send_word(random_row());
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
